// ----- rtl/bldc_ramp_pkg.sv -----
// Shared types and constants for the open-loop startup ramp block.
// Used by the controller, the datapath, the divider and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bldc_ramp_pkg;

    // Field and register widths
    localparam int unsigned STEP_W   = 3;
    localparam int unsigned FREQ_W   = 32;
    localparam int unsigned CLK_W    = 32;
    localparam int unsigned CFGF_W   = 20;
    localparam int unsigned CNT_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Last six-step commutation index
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

    // Register reset values
    localparam logic [CLK_W-1:0]  RST_TIMER_CLOCK = 32'd1000000;
    localparam logic [CFGF_W-1:0] RST_MIN_FREQ    = 20'd100;
    localparam logic [CFGF_W-1:0] RST_MAX_FREQ    = 20'd2000;
    localparam logic [CNT_W-1:0]  RST_STEPS       = 16'd2;
    localparam logic [CFGF_W-1:0] RST_FREQ_INC    = 20'd3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMER_CLOCK = 3'd0,
        REG_MIN_FREQ    = 3'd1,
        REG_MAX_FREQ    = 3'd2,
        REG_STEPS       = 3'd3,
        REG_FREQ_INC    = 3'd4
    } cfg_reg_t;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_FIXED = 2'd2
    } func_t;

    // Controller to datapath commands
    typedef struct packed {
        logic take;      // item accepted this cycle
        logic load_out;  // move pending result into output register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_div;  // accepted item needs a timer reload
        logic div_busy;  // divider still iterating
    } dp_sts_t;

endpackage

`default_nettype wire

// ----- rtl/bldc_ramp_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// Uses bldc_ramp_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module bldc_ramp_div
    import bldc_ramp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CLK_W-1:0]  dividend,
    input  wire logic [FREQ_W-1:0] divisor,
    output logic                   busy,
    output logic [CLK_W-1:0]       quotient
);

    localparam int unsigned ITER_W = $clog2(CLK_W + 1);

    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [CLK_W-1:0]  quo_reg, quo_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] den_reg, den_next;
    logic [FREQ_W:0]   shifted;
    logic [FREQ_W+1:0] trial;

    // One restoring step: shift in next dividend bit, try subtract
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[CLK_W-1]};
        trial     = {1'b0, shifted} - {2'b00, den_reg};
        iter_next = iter_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            iter_next = ITER_W'(CLK_W);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (iter_reg != '0)
        begin
            iter_next = iter_reg - ITER_W'(1);
            if (trial[FREQ_W+1])
            begin
                rem_next = shifted[FREQ_W-1:0];
                quo_next = {quo_reg[CLK_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[FREQ_W-1:0];
                quo_next = {quo_reg[CLK_W-2:0], 1'b1};
            end
        end
    end

    // Iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iter_reg <= '0;
        else
            iter_reg <= iter_next;
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy     = (iter_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/bldc_ramp_dp.sv -----
// Datapath: config registers, ramp state, pending result and output payload.
// Uses bldc_ramp_pkg and instantiates bldc_ramp_div.
`timescale 1ns / 1ps
`default_nettype none

module bldc_ramp_dp
    import bldc_ramp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [1:0]            func,
    input  wire logic                  in_closed_loop,
    input  wire ctrl_cmd_t             cmd,
    output dp_sts_t                    sts,
    output logic [STEP_W-1:0]          step_index,
    output logic                       step_valid,
    output logic [CLK_W-1:0]           timer_reload,
    output logic                       reload_valid,
    output logic                       enter_closed_loop
);

    // Configuration registers
    logic [CLK_W-1:0]  clk_hz_reg;
    logic [CFGF_W-1:0] min_freq_reg;
    logic [CFGF_W-1:0] max_freq_reg;
    logic [CNT_W-1:0]  steps_reg;
    logic [CFGF_W-1:0] freq_inc_reg;

    // Ramp state
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    // Pending result
    logic [STEP_W-1:0] res_step_reg, res_step_next;
    logic              res_sv_reg, res_sv_next;
    logic              res_rv_reg, res_rv_next;
    logic              res_enter_reg, res_enter_next;
    logic              res_zero_reg, res_zero_next;

    // Output payload
    logic [STEP_W-1:0] out_step_reg;
    logic              out_sv_reg;
    logic [CLK_W-1:0]  out_reload_reg, out_reload_next;
    logic              out_rv_reg;
    logic              out_enter_reg;

    logic [STEP_W-1:0] step_adv;
    logic [CNT_W-1:0]  cnt_dec;
    logic [FREQ_W:0]   freq_sum;
    logic [FREQ_W-1:0] freq_sat;
    logic              need_div;
    logic              div_busy;
    logic [CLK_W-1:0]  div_quo;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg   <= RST_TIMER_CLOCK;
            min_freq_reg <= RST_MIN_FREQ;
            max_freq_reg <= RST_MAX_FREQ;
            steps_reg    <= RST_STEPS;
            freq_inc_reg <= RST_FREQ_INC;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TIMER_CLOCK: clk_hz_reg   <= cfg_data;
                REG_MIN_FREQ:    min_freq_reg <= cfg_data[CFGF_W-1:0];
                REG_MAX_FREQ:    max_freq_reg <= cfg_data[CFGF_W-1:0];
                REG_STEPS:       steps_reg    <= cfg_data[CNT_W-1:0];
                REG_FREQ_INC:    freq_inc_reg <= cfg_data[CFGF_W-1:0];
                default:         ;
            endcase
        end
    end

    // Step advance, countdown and saturating frequency add
    assign step_adv = (step_reg >= STEP_LAST) ? '0 : step_reg + STEP_W'(1);
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign freq_sum = {1'b0, freq_reg} + (FREQ_W + 1)'(freq_inc_reg);
    assign freq_sat = freq_sum[FREQ_W] ? '1 : freq_sum[FREQ_W-1:0];

    // Item decode
    always_comb
    begin
        freq_next      = freq_reg;
        step_next      = step_reg;
        cnt_next       = cnt_reg;
        res_step_next  = '0;
        res_sv_next    = 1'b0;
        res_rv_next    = 1'b0;
        res_enter_next = 1'b0;
        need_div       = 1'b0;
        unique case (func)
            FUNC_BEGIN:
            begin
                freq_next     = FREQ_W'(min_freq_reg);
                cnt_next      = steps_reg - CNT_W'(1);
                res_step_next = step_reg;
                res_sv_next   = 1'b1;
                res_rv_next   = 1'b1;
                need_div      = 1'b1;
            end
            FUNC_TICK:
            begin
                if (!in_closed_loop)
                begin
                    step_next     = step_adv;
                    res_step_next = step_adv;
                    res_sv_next   = 1'b1;
                    if (cnt_dec != '0)
                        cnt_next = cnt_dec;
                    else
                    begin
                        // countdown expired: next frequency and reload
                        cnt_next       = steps_reg;
                        freq_next      = freq_sat;
                        res_rv_next    = 1'b1;
                        res_enter_next = (freq_sat >= FREQ_W'(max_freq_reg));
                        need_div       = 1'b1;
                    end
                end
            end
            FUNC_FIXED:
            begin
                step_next     = step_adv;
                res_step_next = step_adv;
                res_sv_next   = 1'b1;
            end
            default: ;
        endcase
        res_zero_next = (freq_next == '0);
    end

    // Ramp state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg <= FREQ_W'(RST_MIN_FREQ);
            step_reg <= '0;
            cnt_reg  <= RST_STEPS;
        end
        else if (cmd.take)
        begin
            freq_reg <= freq_next;
            step_reg <= step_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Pending result capture
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            res_step_reg  <= res_step_next;
            res_sv_reg    <= res_sv_next;
            res_rv_reg    <= res_rv_next;
            res_enter_reg <= res_enter_next;
            res_zero_reg  <= res_zero_next;
        end
    end

    // Reload = clock / frequency - 1, all ones for zero frequency
    bldc_ramp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.take && need_div),
        .dividend (clk_hz_reg),
        .divisor  (freq_next),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_comb
    begin
        if (!res_rv_reg)
            out_reload_next = '0;
        else if (res_zero_reg)
            out_reload_next = '1;
        else
            out_reload_next = div_quo - CLK_W'(1);
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_step_reg   <= res_step_reg;
            out_sv_reg     <= res_sv_reg;
            out_reload_reg <= out_reload_next;
            out_rv_reg     <= res_rv_reg;
            out_enter_reg  <= res_enter_reg;
        end
    end

    assign sts.need_div      = need_div;
    assign sts.div_busy      = div_busy;
    assign step_index        = out_step_reg;
    assign step_valid        = out_sv_reg;
    assign timer_reload      = out_reload_reg;
    assign reload_valid      = out_rv_reg;
    assign enter_closed_loop = out_enter_reg;

endmodule

`default_nettype wire

// ----- rtl/bldc_ramp_ctrl.sv -----
// Controller: input/output handshake and sequencing of the divider.
// Uses bldc_ramp_pkg command and status types.
`timescale 1ns / 1ps
`default_nettype none

module bldc_ramp_ctrl
    import bldc_ramp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    output logic         out_valid,
    input  wire logic    out_stall,
    output ctrl_cmd_t    cmd,
    input  wire dp_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   take;
    logic   load_out;

    assign take     = in_valid && (state_reg == S_IDLE);
    assign load_out = (state_reg == S_PUSH) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                    state_next = sts.need_div ? S_DIV : S_PUSH;
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                    state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign cmd.take     = take;
    assign cmd.load_out = load_out;

endmodule

`default_nettype wire

// ----- rtl/bldc_open_loop_startup_ramp_core.sv -----
// Open-loop startup ramp for a six-step brushless motor drive.
// Input channel: func / in_closed_loop with in_valid, in_stall.
// Output channel: step_index, step_valid, timer_reload, reload_valid,
// enter_closed_loop with out_valid, out_stall. One result per item.
// Config port: cfg_we, cfg_index, cfg_data; write only while idle.
// Registers: 0 timer clock, 1 min freq, 2 max freq, 3 steps per
// increment, 4 frequency increment. Unknown indexes are ignored.
// Timing: an item without a timer reload is held in the pending result
// register on acceptance and moves into the output register once the
// slot is free. An item with a reload (begin, or a ramp tick that ends
// a countdown) first runs the serial divider, then moves the same way.
// One item is in work at a time: in_stall is high from acceptance until
// the result enters the output register.
// A stalled result holds in the output register; the next item may be
// accepted and worked meanwhile and then waits for the slot.
// Reset: registers to their defaults, step 0, frequency 100 Hz,
// countdown 2, no result pending.
// Uses bldc_ramp_pkg; instantiates bldc_ramp_ctrl and bldc_ramp_dp.
`timescale 1ns / 1ps
`default_nettype none

module bldc_open_loop_startup_ramp_core
    import bldc_ramp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            func,
    input  wire logic                  in_closed_loop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [STEP_W-1:0]          step_index,
    output logic                       step_valid,
    output logic [CLK_W-1:0]           timer_reload,
    output logic                       reload_valid,
    output logic                       enter_closed_loop
);

    ctrl_cmd_t cmd;
    dp_sts_t   sts;

    // Handshake and sequencing
    bldc_ramp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // Ramp state, divider and result registers
    bldc_ramp_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .func              (func),
        .in_closed_loop    (in_closed_loop),
        .cmd               (cmd),
        .sts               (sts),
        .step_index        (step_index),
        .step_valid        (step_valid),
        .timer_reload      (timer_reload),
        .reload_valid      (reload_valid),
        .enter_closed_loop (enter_closed_loop)
    );

endmodule

`default_nettype wire

// ----- rtl/bldc_ramp_chk.sv -----
// Port-level checks for the startup ramp block, bound to the top level.
// Uses bldc_ramp_pkg for widths and the step limit.
`timescale 1ns / 1ps
`default_nettype none

module bldc_ramp_chk
    import bldc_ramp_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [STEP_W-1:0] step_index,
    input wire logic              step_valid,
    input wire logic [CLK_W-1:0]  timer_reload,
    input wire logic              reload_valid,
    input wire logic              enter_closed_loop
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item accepted while busy");

    // No reload means zero reload value and no handover
    a_no_reload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !reload_valid |-> timer_reload == '0 && !enter_closed_loop)
        else $error("reload fields set without reload_valid");

    // Emitted commutation step stays within six-step range
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_valid |-> step_index <= STEP_LAST)
        else $error("step index out of range");

    // An empty result carries nothing
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !step_valid |-> step_index == '0 && !reload_valid)
        else $error("empty result carries data");

endmodule

bind bldc_open_loop_startup_ramp_core bldc_ramp_chk u_bldc_ramp_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .step_index        (step_index),
    .step_valid        (step_valid),
    .timer_reload      (timer_reload),
    .reload_valid      (reload_valid),
    .enter_closed_loop (enter_closed_loop)
);

`default_nettype wire
